FILE: rtl/core/pscm_pkg.sv
`default_nettype none

package pscm_pkg;

	// number of size classes and their object sizes in bytes
	localparam int NCLASS = 9;
	localparam logic [11:0] CLASS_BYTES [NCLASS] = '{
		12'h010, 12'h020, 12'h040, 12'h080, 12'h100,
		12'h200, 12'h300, 12'h400, 12'h800
	};

	// largest small request
	localparam logic [31:0] SMALL_MAX = 32'h0000_0800;

	// kernel address windows, lower bound inclusive, upper bound exclusive
	localparam logic [63:0] DIRECT_LO = 64'hffff_8000_0000_0000;
	localparam logic [63:0] DIRECT_HI = 64'hffff_9000_0000_0000;
	localparam logic [63:0] STATIC_LO = 64'hffff_ffff_8000_0000;
	localparam logic [63:0] STATIC_HI = 64'hffff_ffff_c000_0000;

	// request types
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_MISS     = 3'd1,
		ST_NOTSMALL = 3'd2,
		ST_NULLREQ  = 3'd3,
		ST_CACHED   = 3'd4,
		ST_RELEASE  = 3'd5,
		ST_IGNNULL  = 3'd6,
		ST_REJECT   = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CNT,
		S_HIT,
		S_FL_RD,
		S_FL_OUT,
		S_RESP
	} state_t;

	// decode of one request: either it needs the stacks, or the answer is known
	typedef struct packed {
		logic        fast;
		status_t     status;
		logic [3:0]  size_class;
		logic [63:0] block_address;
	} req_info_t;

endpackage

`default_nettype wire

FILE: rtl/core/pscm_req_if.sv
`default_nettype none

interface pscm_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [1:0]  cpu_id;
	logic [31:0] size;
	logic [63:0] address;
	logic [11:0] object_size;

	modport source (
		output valid, req_type, cpu_id, size, address, object_size,
		input  ready
	);
	modport sink (
		input  valid, req_type, cpu_id, size, address, object_size,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/pscm_rsp_if.sv
`default_nettype none

interface pscm_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] block_address;
	logic [3:0]  size_class;
	logic        last;

	modport source (
		output valid, status, block_address, size_class, last,
		input  ready
	);
	modport sink (
		input  valid, status, block_address, size_class, last,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/core/per_cpu_slab_magazine_cache.sv
`default_nettype none

// channel   | role | payload
// ----------+------+--------------------------------------------------
// req       | in   | req_type, cpu_id, size, address, object_size
// rsp       | out  | status, block_address, size_class, last
// cfg       | in   | cfg_write / cfg_data: cache_enable, write only
//
// one transaction in flight: requests answered without the stacks go straight to the
// response state, a cached free reads the count first, an allocate hit reads the count and
// then the magazine, and a full-stack flush reads and releases each entry in turn.
// reset clears the control state and the per-stack valid bits; counts read as zero.
// a stalled rsp holds the output register; the fsm waits on it before loading again.

module per_cpu_slab_magazine_cache #(
	parameter int CPUS           = 4,
	parameter int MAGAZINE_DEPTH = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_write,
	input  wire logic  cfg_data,
	pscm_req_if.sink   req,
	pscm_rsp_if.source rsp
);

	localparam int NSTACK   = CPUS * pscm_pkg::NCLASS;
	localparam int NENTRY   = NSTACK * MAGAZINE_DEPTH;
	localparam int STACK_AW = (NSTACK > 1) ? $clog2(NSTACK) : 1;
	localparam int STORE_AW = (NENTRY > 1) ? $clog2(NENTRY) : 1;
	localparam int CW       = $clog2(MAGAZINE_DEPTH + 1);
	localparam int IW       = (MAGAZINE_DEPTH > 1) ? $clog2(MAGAZINE_DEPTH) : 1;
	localparam int SUM_W    = STACK_AW + 8;

	localparam logic [CW-1:0]       DEPTH_C  = CW'(MAGAZINE_DEPTH);
	localparam logic [STORE_AW-1:0] DEPTH_A  = STORE_AW'(MAGAZINE_DEPTH);
	localparam logic [IW-1:0]       IDX_LAST = IW'(MAGAZINE_DEPTH - 1);

	pscm_pkg::state_t    state_q, state_d;
	pscm_pkg::req_info_t info;

	logic                cache_enable_q;
	logic                req_fire;
	logic                out_free;

	// request registers
	logic                type_s1;
	logic [3:0]          cls_s1;
	logic [63:0]         addr_s1;
	logic [STACK_AW-1:0] stack_s1;
	logic [SUM_W-1:0]    stack_sum;
	logic [STACK_AW-1:0] stack_n;

	// pending single result
	pscm_pkg::status_t   res_status_q, res_status_n;
	logic [63:0]         res_addr_q, res_addr_n;
	logic                res_ld;

	// count memory with per-stack valid bits
	logic [CW-1:0]       cnt_mem [NSTACK];
	logic [NSTACK-1:0]   cnt_vld_q;
	logic [CW-1:0]       cnt_rd_q;
	logic                cnt_vld_rd_q;
	logic                cnt_re, cnt_we;
	logic [CW-1:0]       cnt_wd;
	logic [CW-1:0]       cnt_cur;

	// magazine memory
	logic [63:0]         store_mem [NENTRY];
	logic [63:0]         store_rd_q;
	logic                st_re, st_we;
	logic [STORE_AW-1:0] st_ra, st_wa;
	logic [STORE_AW-1:0] base_addr;

	// flush walk
	logic [IW-1:0]       idx_q;
	logic                idx_clr, idx_inc;
	logic                flush_last;

	// output register
	logic                rsp_valid_q;
	pscm_pkg::status_t   rsp_status_q, out_status;
	logic [63:0]         rsp_addr_q, out_addr;
	logic [3:0]          rsp_cls_q;
	logic                rsp_last_q, out_last;
	logic                out_ld;

	pscm_classify #(
		.CPUS (CPUS)
	) u_classify (
		.cache_enable (cache_enable_q),
		.req_type     (req.req_type),
		.cpu_id       (req.cpu_id),
		.size         (req.size),
		.address      (req.address),
		.object_size  (req.object_size),
		.info         (info)
	);

	assign req.ready = (state_q == pscm_pkg::S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// stack index of the incoming request
	assign stack_sum = SUM_W'(req.cpu_id) * SUM_W'(pscm_pkg::NCLASS) + SUM_W'(info.size_class);
	assign stack_n   = stack_sum[STACK_AW-1:0];

	assign base_addr  = STORE_AW'(stack_s1) * DEPTH_A;
	assign cnt_cur    = cnt_vld_rd_q ? cnt_rd_q : '0;
	assign flush_last = (idx_q == IDX_LAST);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_enable_q <= 1'b0;
		end else if (cfg_write) begin
			cache_enable_q <= cfg_data;
		end
	end

	// capture the accepted transaction
	always_ff @(posedge clk) begin
		if (req_fire) begin
			type_s1  <= req.req_type;
			cls_s1   <= info.size_class;
			addr_s1  <= req.address;
			stack_s1 <= stack_n;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			res_status_q <= info.status;
			res_addr_q   <= info.block_address;
		end else if (res_ld) begin
			res_status_q <= res_status_n;
			res_addr_q   <= res_addr_n;
		end
	end

	// count memory
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[stack_s1] <= cnt_wd;
		end
		if (cnt_re) begin
			cnt_rd_q <= cnt_mem[stack_n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q    <= '0;
			cnt_vld_rd_q <= 1'b0;
		end else begin
			if (cnt_we) begin
				cnt_vld_q[stack_s1] <= 1'b1;
			end
			if (cnt_re) begin
				cnt_vld_rd_q <= cnt_vld_q[stack_n];
			end
		end
	end

	// magazine memory
	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_wa] <= addr_s1;
		end
		if (st_re) begin
			store_rd_q <= store_mem[st_ra];
		end
	end

	// flush index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (idx_clr) begin
			idx_q <= '0;
		end else if (idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pscm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control
	always_comb begin
		state_d      = state_q;
		cnt_re       = 1'b0;
		cnt_we       = 1'b0;
		cnt_wd       = cnt_cur;
		st_re        = 1'b0;
		st_ra        = base_addr + STORE_AW'(idx_q);
		st_we        = 1'b0;
		st_wa        = base_addr + STORE_AW'(cnt_cur);
		res_ld       = 1'b0;
		res_status_n = res_status_q;
		res_addr_n   = res_addr_q;
		idx_clr      = 1'b0;
		idx_inc      = 1'b0;
		out_ld       = 1'b0;
		out_status   = res_status_q;
		out_addr     = res_addr_q;
		out_last     = 1'b1;
		case (state_q)
			pscm_pkg::S_IDLE: begin
				if (req_fire) begin
					if (info.fast) begin
						cnt_re  = 1'b1;
						state_d = pscm_pkg::S_CNT;
					end else begin
						state_d = pscm_pkg::S_RESP;
					end
				end
			end
			pscm_pkg::S_CNT: begin
				if (type_s1 == pscm_pkg::REQ_ALLOC) begin
					if (cnt_cur != '0) begin
						// pop: read the top entry
						cnt_we  = 1'b1;
						cnt_wd  = cnt_cur - CW'(1);
						st_re   = 1'b1;
						st_ra   = base_addr + STORE_AW'(cnt_cur) - STORE_AW'(1);
						state_d = pscm_pkg::S_HIT;
					end else begin
						res_ld       = 1'b1;
						res_status_n = pscm_pkg::ST_MISS;
						res_addr_n   = 64'd0;
						state_d      = pscm_pkg::S_RESP;
					end
				end else if (cnt_cur < DEPTH_C) begin
					// push onto a stack with room
					st_we        = 1'b1;
					cnt_we       = 1'b1;
					cnt_wd       = cnt_cur + CW'(1);
					res_ld       = 1'b1;
					res_status_n = pscm_pkg::ST_CACHED;
					res_addr_n   = addr_s1;
					state_d      = pscm_pkg::S_RESP;
				end else begin
					idx_clr = 1'b1;
					state_d = pscm_pkg::S_FL_RD;
				end
			end
			pscm_pkg::S_HIT: begin
				res_ld       = 1'b1;
				res_status_n = pscm_pkg::ST_HIT;
				res_addr_n   = store_rd_q;
				state_d      = pscm_pkg::S_RESP;
			end
			pscm_pkg::S_FL_RD: begin
				st_re   = 1'b1;
				state_d = pscm_pkg::S_FL_OUT;
			end
			pscm_pkg::S_FL_OUT: begin
				if (out_free) begin
					out_ld     = 1'b1;
					out_status = pscm_pkg::ST_RELEASE;
					out_addr   = store_rd_q;
					out_last   = flush_last;
					if (flush_last) begin
						// stack restarts with the new address only
						st_we   = 1'b1;
						st_wa   = base_addr;
						cnt_we  = 1'b1;
						cnt_wd  = CW'(1);
						state_d = pscm_pkg::S_IDLE;
					end else begin
						idx_inc = 1'b1;
						state_d = pscm_pkg::S_FL_RD;
					end
				end
			end
			pscm_pkg::S_RESP: begin
				if (out_free) begin
					out_ld  = 1'b1;
					state_d = pscm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pscm_pkg::S_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_ld) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			rsp_status_q <= out_status;
			rsp_addr_q   <= out_addr;
			rsp_cls_q    <= cls_s1;
			rsp_last_q   <= out_last;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.block_address = rsp_addr_q;
	assign rsp.size_class    = rsp_cls_q;
	assign rsp.last          = rsp_last_q;

	// a stack count never goes past the magazine depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> (cnt_wd <= DEPTH_C))
		else $error("stack count written above magazine depth");

	// only flush transactions are followed by more results of the same request
	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.last) |-> (rsp.status == pscm_pkg::ST_RELEASE))
		else $error("non-final result that is not a release");

	// an accepted request always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q != pscm_pkg::S_IDLE))
		else $error("request accepted without leaving idle");

	// a hit read always follows the count lookup
	a_hit_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pscm_pkg::S_HIT) |-> ($past(state_q) == pscm_pkg::S_CNT))
		else $error("hit state entered out of order");

endmodule

`default_nettype wire

FILE: rtl/core/pscm_classify.sv
`default_nettype none

module pscm_classify #(
	parameter int CPUS = 4
) (
	input  wire logic              cache_enable,
	input  wire logic              req_type,
	input  wire logic [1:0]        cpu_id,
	input  wire logic [31:0]       size,
	input  wire logic [63:0]       address,
	input  wire logic [11:0]       object_size,
	output pscm_pkg::req_info_t    info
);

	logic [3:0] cls_size;
	logic [3:0] cls_slab;
	logic       slab_hit;
	logic       cpu_ok;
	logic       in_window;

	// smallest class holding the size, and exact match on the slab size
	always_comb begin
		cls_size = 4'd0;
		cls_slab = 4'd0;
		slab_hit = 1'b0;
		for (int i = pscm_pkg::NCLASS - 1; i >= 0; i--) begin
			if (size <= 32'(pscm_pkg::CLASS_BYTES[i])) begin
				cls_size = 4'(i);
			end
			if (object_size == pscm_pkg::CLASS_BYTES[i]) begin
				cls_slab = 4'(i);
				slab_hit = 1'b1;
			end
		end
	end

	assign cpu_ok = int'(cpu_id) < CPUS;

	assign in_window =
		(address >= pscm_pkg::DIRECT_LO && address < pscm_pkg::DIRECT_HI) ||
		(address >= pscm_pkg::STATIC_LO && address < pscm_pkg::STATIC_HI);

	// immediate answers, or hand over to the stack logic
	always_comb begin
		info.fast          = 1'b0;
		info.status        = pscm_pkg::ST_MISS;
		info.size_class    = 4'd0;
		info.block_address = 64'd0;
		if (req_type == pscm_pkg::REQ_ALLOC) begin
			if (size == 32'd0) begin
				info.status = pscm_pkg::ST_NULLREQ;
			end else if (size > pscm_pkg::SMALL_MAX) begin
				info.status = pscm_pkg::ST_NOTSMALL;
			end else begin
				info.status     = pscm_pkg::ST_MISS;
				info.size_class = cls_size;
				info.fast       = cache_enable && cpu_ok;
			end
		end else begin
			if (address == 64'd0) begin
				info.status = pscm_pkg::ST_IGNNULL;
			end else if (!in_window) begin
				info.status = pscm_pkg::ST_REJECT;
			end else begin
				info.status        = pscm_pkg::ST_RELEASE;
				info.block_address = address;
				info.size_class    = slab_hit ? cls_slab : 4'd0;
				info.fast          = cache_enable && cpu_ok && slab_hit;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sim/magazine_checker.sv
`timescale 1ns / 100ps

module magazine_checker #(
	parameter int CPUS           = 4,
	parameter int MAGAZINE_DEPTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_write,
	input  wire logic cfg_data,
	pscm_req_if       req,
	pscm_rsp_if       rsp,
	output int        errors,
	output int        pending
);

	typedef struct {
		pscm_pkg::status_t status;
		logic [63:0]       block_address;
		logic [3:0]        size_class;
		logic              last;
	} outcome_t;

	outcome_t    outcome_q[$];
	logic [63:0] magazines [CPUS][pscm_pkg::NCLASS][MAGAZINE_DEPTH];
	int          depth_of [CPUS][pscm_pkg::NCLASS];
	logic        enable_model;
	int          resp_seen;

	// smallest class that holds an allocate size
	function automatic int class_for_size(logic [31:0] nbytes);
		for (int i = 0; i < pscm_pkg::NCLASS; i++)
			if (nbytes <= 32'(pscm_pkg::CLASS_BYTES[i]))
				return i;
		return -1;
	endfunction

	// class whose object size matches the slab size exactly
	function automatic int class_for_slab(logic [11:0] slab);
		if (slab == 12'd0)
			return -1;
		for (int i = 0; i < pscm_pkg::NCLASS; i++)
			if (slab == pscm_pkg::CLASS_BYTES[i])
				return i;
		return -1;
	endfunction

	task automatic queue_outcome(pscm_pkg::status_t st, logic [63:0] addr, int cls,
			logic last);
		outcome_t o;
		o.status = st;
		o.block_address = addr;
		o.size_class = (cls < 0) ? 4'd0 : 4'(cls);
		o.last = last;
		outcome_q.push_back(o);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch at response %0d: %s got %h want %h", resp_seen, what, got, want);
	endtask

	// work out the responses one request transaction causes
	task automatic predict_request(logic rtype, logic [1:0] cpu, logic [31:0] nbytes,
			logic [63:0] addr, logic [11:0] slab);
		int cls;
		bit fast;
		bit in_window;
		fast = enable_model && (int'(cpu) < CPUS);
		if (rtype == pscm_pkg::REQ_ALLOC) begin
			if (nbytes == 32'd0) begin
				queue_outcome(pscm_pkg::ST_NULLREQ, '0, -1, 1'b1);
			end else if (nbytes > pscm_pkg::SMALL_MAX) begin
				queue_outcome(pscm_pkg::ST_NOTSMALL, '0, -1, 1'b1);
			end else begin
				cls = class_for_size(nbytes);
				if (fast && depth_of[cpu][cls] > 0) begin
					depth_of[cpu][cls]--;
					queue_outcome(pscm_pkg::ST_HIT, magazines[cpu][cls][depth_of[cpu][cls]],
						cls, 1'b1);
				end else begin
					queue_outcome(pscm_pkg::ST_MISS, '0, cls, 1'b1);
				end
			end
		end else begin
			in_window = (addr >= pscm_pkg::DIRECT_LO && addr < pscm_pkg::DIRECT_HI) ||
				(addr >= pscm_pkg::STATIC_LO && addr < pscm_pkg::STATIC_HI);
			cls = class_for_slab(slab);
			if (addr == 64'd0) begin
				queue_outcome(pscm_pkg::ST_IGNNULL, '0, -1, 1'b1);
			end else if (!in_window) begin
				queue_outcome(pscm_pkg::ST_REJECT, '0, -1, 1'b1);
			end else if (!fast || cls < 0) begin
				queue_outcome(pscm_pkg::ST_RELEASE, addr, cls, 1'b1);
			end else if (depth_of[cpu][cls] < MAGAZINE_DEPTH) begin
				magazines[cpu][cls][depth_of[cpu][cls]] = addr;
				depth_of[cpu][cls]++;
				queue_outcome(pscm_pkg::ST_CACHED, addr, cls, 1'b1);
			end else begin
				// full stack: release everything oldest first, keep only the new block
				for (int i = 0; i < MAGAZINE_DEPTH; i++)
					queue_outcome(pscm_pkg::ST_RELEASE, magazines[cpu][cls][i], cls,
						(i == MAGAZINE_DEPTH - 1));
				magazines[cpu][cls][0] = addr;
				depth_of[cpu][cls] = 1;
			end
		end
	endtask

	// compare one response transaction with the oldest outstanding outcome
	task automatic check_response();
		outcome_t want;
		resp_seen++;
		if (outcome_q.size() == 0) begin
			report_mismatch("response with nothing outstanding, address",
				rsp.block_address, '0);
		end else begin
			want = outcome_q.pop_front();
			if (rsp.status !== want.status)
				report_mismatch("status", 64'(rsp.status), 64'(want.status));
			if (rsp.block_address !== want.block_address)
				report_mismatch("block_address", rsp.block_address, want.block_address);
			if (rsp.size_class !== want.size_class)
				report_mismatch("size_class", 64'(rsp.size_class), 64'(want.size_class));
			if (rsp.last !== want.last)
				report_mismatch("last", 64'(rsp.last), 64'(want.last));
		end
	endtask

	// watch config, request and response channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_model = 1'b0;
			foreach (depth_of[c, k])
				depth_of[c][k] = 0;
			outcome_q.delete();
			errors = 0;
			resp_seen = 0;
			pending = 0;
		end else begin
			if (req.valid && req.ready)
				predict_request(req.req_type, req.cpu_id, req.size, req.address,
					req.object_size);
			if (rsp.valid && rsp.ready)
				check_response();
			if (cfg_write)
				enable_model = cfg_data;
			pending = outcome_q.size();
		end
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int CPUS           = 4;
	localparam int MAGAZINE_DEPTH = 32;
	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int SETTLE_CYCLES  = 2 * MAGAZINE_DEPTH + 8;
	localparam int PHASE_ITEMS    = 90;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic cfg_data;
	int   errors;
	int   pending;
	int   cycles = 0;
	bit   calm = 1'b0;
	int   items_sent = 0;

	pscm_req_if req_ch ();
	pscm_rsp_if rsp_ch ();

	per_cpu_slab_magazine_cache #(
		.CPUS           (CPUS),
		.MAGAZINE_DEPTH (MAGAZINE_DEPTH)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	magazine_checker #(
		.CPUS           (CPUS),
		.MAGAZINE_DEPTH (MAGAZINE_DEPTH)
	) mag_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.errors    (errors),
		.pending   (pending)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(14, 0);
	endfunction

	// random block address inside one of the two windows, edges now and then
	function automatic logic [63:0] window_address();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(9, 0))
			0: return pscm_pkg::DIRECT_LO;
			1: return pscm_pkg::DIRECT_HI - 64'd1;
			2: return pscm_pkg::STATIC_LO;
			3: return pscm_pkg::STATIC_HI - 64'd1;
			4, 5, 6: return pscm_pkg::DIRECT_LO + (r & 64'h0000_0fff_ffff_ffff);
			default: return pscm_pkg::STATIC_LO + (r & 64'h0000_0000_3fff_ffff);
		endcase
	endfunction

	// allocate size that maps to the given class
	function automatic logic [31:0] size_in_class(int cls);
		int lo;
		lo = 1;
		if (cls > 0)
			lo = int'(pscm_pkg::CLASS_BYTES[cls - 1]) + 1;
		return $urandom_range(int'(pscm_pkg::CLASS_BYTES[cls]), lo);
	endfunction

	// response side: random stall before each transaction
	initial begin : rsp_sink
		int gap;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			@(negedge clk);
		end
	end

	// one request transaction, called and returning at a falling edge
	task automatic send_request(logic rtype, logic [1:0] cpu, logic [31:0] nbytes,
			logic [63:0] addr, logic [11:0] slab);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= rtype;
		req_ch.cpu_id <= cpu;
		req_ch.size <= nbytes;
		req_ch.address <= addr;
		req_ch.object_size <= slab;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_alloc(logic [1:0] cpu, logic [31:0] nbytes);
		send_request(pscm_pkg::REQ_ALLOC, cpu, nbytes, {$urandom, $urandom}, 12'($urandom));
	endtask

	task automatic send_free(logic [1:0] cpu, logic [63:0] addr, logic [11:0] slab);
		send_request(pscm_pkg::REQ_FREE, cpu, $urandom, addr, slab);
	endtask

	// any request at all, fields spread over their whole range
	task automatic send_noise();
		logic [63:0] addr;
		logic [11:0] slab;
		logic [31:0] nbytes;
		case ($urandom_range(3, 0))
			0: addr = {$urandom, $urandom};
			1: addr = '0;
			default: addr = window_address();
		endcase
		case ($urandom_range(3, 0))
			0: nbytes = $urandom;
			1: nbytes = '0;
			default: nbytes = $urandom_range(2100, 1);
		endcase
		slab = $urandom_range(1, 0) ? 12'($urandom) :
			pscm_pkg::CLASS_BYTES[$urandom_range(pscm_pkg::NCLASS - 1, 0)];
		send_request($urandom_range(1, 0) ? pscm_pkg::REQ_FREE : pscm_pkg::REQ_ALLOC,
			2'($urandom), nbytes, addr, slab);
	endtask

	// hold off until every outstanding response has arrived
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_cache_enable(logic value);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// stimulus and verdict
	initial begin : stimulus
		logic [1:0] hot_cpu;
		int         hot_cls;
		logic [1:0] cpu;
		int         cls;
		int         n;
		int         phase_end;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = pscm_pkg::REQ_ALLOC;
		req_ch.cpu_id = '0;
		req_ch.size = '0;
		req_ch.address = '0;
		req_ch.object_size = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// cache disabled out of reset
		send_alloc(2'd0, 32'd0);
		send_alloc(2'd1, 32'hffff_ffff);
		send_free(2'd2, 64'd0, 12'h010);
		send_free(2'd0, pscm_pkg::DIRECT_LO, 12'h010);

		// size and window edges, unknown and unmatched slab sizes
		set_cache_enable(1'b1);
		send_alloc(2'd0, 32'd1);
		send_alloc(2'd1, pscm_pkg::SMALL_MAX + 32'd1);
		send_free(2'd0, pscm_pkg::DIRECT_HI, 12'h010);
		send_free(2'd1, pscm_pkg::STATIC_LO - 64'd1, 12'h010);
		send_free(2'd2, pscm_pkg::STATIC_HI, 12'h010);
		send_free(2'd3, 64'hffff_ffff_ffff_ffff, 12'h010);
		send_free(2'd0, pscm_pkg::DIRECT_HI - 64'd1, 12'h000);
		send_free(2'd1, pscm_pkg::STATIC_HI - 64'd1, 12'h030);
		send_free(2'd0, window_address(), 12'hfff);

		// push then pop on one cpu
		send_free(2'd3, pscm_pkg::DIRECT_LO, 12'h800);
		send_free(2'd3, pscm_pkg::STATIC_LO, 12'h300);
		send_alloc(2'd3, pscm_pkg::SMALL_MAX);
		send_alloc(2'd3, 32'h201);
		send_alloc(2'd3, 32'h300);

		// every class once
		for (int k = 0; k < pscm_pkg::NCLASS; k++)
			send_free(2'(k), window_address(), pscm_pkg::CLASS_BYTES[k]);

		// random phases, cache switched off in one of them
		for (int phase = 0; phase < 4; phase++) begin
			set_cache_enable(phase != 1);
			hot_cpu = 2'($urandom);
			hot_cls = $urandom_range(pscm_pkg::NCLASS - 1, 0);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				calm = ($urandom_range(3, 0) == 0);
				cpu = 2'($urandom);
				cls = $urandom_range(pscm_pkg::NCLASS - 1, 0);
				if ($urandom_range(1, 0)) begin
					cpu = hot_cpu;
					cls = hot_cls;
				end
				case ($urandom_range(9, 0))
					// free bursts fill stacks toward a flush
					0, 1, 2, 3: begin
						n = $urandom_range(40, 1);
						repeat (n) send_free(cpu, window_address(), pscm_pkg::CLASS_BYTES[cls]);
					end
					4, 5: begin
						n = $urandom_range(20, 1);
						repeat (n) send_alloc(cpu, size_in_class(cls));
					end
					6: begin
						n = $urandom_range(16, 1);
						repeat (n) begin
							if ($urandom_range(1, 0))
								send_free(cpu, window_address(), pscm_pkg::CLASS_BYTES[cls]);
							else
								send_alloc(cpu, size_in_class(cls));
						end
					end
					7: wait_idle();
					default: begin
						n = $urandom_range(8, 1);
						repeat (n) send_noise();
					end
				endcase
			end
		end
		calm = 1'b0;

		wait_idle();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/pscm_pkg.sv
rtl/core/pscm_req_if.sv
rtl/core/pscm_rsp_if.sv
rtl/core/pscm_classify.sv
rtl/core/per_cpu_slab_magazine_cache.sv
sim/magazine_checker.sv
sim/tb.sv
